// File: sv/tgr_pkg.sv
// Shared types, font constants and font tables of the text glyph rectangle generator.
// No dependencies; imported by tgr_addu, tgr_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_COUNT = 69;
    localparam int GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;
    localparam int IDX_W       = $clog2(GLYPH_COUNT);
    localparam int COL_W       = $clog2(GLYPH_COLS);

    localparam int COORD_W = 13;
    localparam int POS_W   = 12;
    localparam int SCALE_W = 4;
    localparam int COLOR_W = 24;
    localparam int CHAR_W  = 8;
    localparam int MULT_W  = 7;   // scale times the largest multiple (6)

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_SMALL_X = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_FOLD    = 8'd32;
    localparam logic [IDX_W-1:0]  IDX_LETTERS  = 7'd10;
    localparam logic [IDX_W-1:0]  IDX_SMALL_X  = IDX_W'(GLYPH_COUNT - 1);

    // multiples of scale produced by the shared adder
    typedef enum logic [1:0] {
        MUL1,
        MUL2,
        MUL4,
        MUL6
    } t_mul;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic               first;
        logic [POS_W-1:0]   start_x;
        logic [POS_W-1:0]   start_y;
        logic [SCALE_W-1:0] scale;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0] rect_x0;
        logic [COORD_W-1:0] rect_y0;
        logic [COORD_W-1:0] rect_x1;
        logic [COORD_W-1:0] rect_y1;
        logic [COLOR_W-1:0] fill_color;
        logic               has_rect;
        logic [COORD_W-1:0] cursor_after;
        logic               last;
    } t_beat;

    typedef struct packed {
        logic  vld;
        t_beat beat;
    } t_emit;

    typedef struct packed {
        logic             known;
        logic [IDX_W-1:0] idx;
    } t_gsel;

    // Character to glyph index, with case folding and the small x after a zero.
    function automatic t_gsel glyph_find(input logic [CHAR_W-1:0] code,
                                         input logic [CHAR_W-1:0] prev);
        logic [CHAR_W-1:0] c;
        t_gsel             g;
        c = code;
        if (code >= CHAR_LOW_A && code <= CHAR_LOW_Z) c = code - CASE_FOLD;
        g.known = 1'b1;
        g.idx   = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            g.idx = IDX_W'(c - CHAR_ZERO);
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            g.idx = IDX_W'(c - CHAR_UP_A) + IDX_LETTERS;
        end else begin
            case (c)
                8'h2E: g.idx = 7'd36;
                8'h2D: g.idx = 7'd37;
                8'h3A: g.idx = 7'd38;
                8'h2F: g.idx = 7'd39;
                8'h28: g.idx = 7'd40;
                8'h29: g.idx = 7'd41;
                8'h2B: g.idx = 7'd42;
                8'h20: g.idx = 7'd43;
                8'h5F: g.idx = 7'd44;
                8'h2C: g.idx = 7'd45;
                8'h3D: g.idx = 7'd46;
                8'h7C: g.idx = 7'd47;
                8'h23: g.idx = 7'd48;
                8'h25: g.idx = 7'd49;
                8'h5B: g.idx = 7'd50;
                8'h5D: g.idx = 7'd51;
                8'h3C: g.idx = 7'd52;
                8'h3E: g.idx = 7'd53;
                8'h21: g.idx = 7'd54;
                8'h3F: g.idx = 7'd55;
                8'h27: g.idx = 7'd56;
                8'h22: g.idx = 7'd57;
                8'h2A: g.idx = 7'd58;
                8'h26: g.idx = 7'd59;
                8'h40: g.idx = 7'd60;
                8'h24: g.idx = 7'd61;
                8'h3B: g.idx = 7'd62;
                8'h7B: g.idx = 7'd63;
                8'h7D: g.idx = 7'd64;
                8'h7E: g.idx = 7'd65;
                8'h5E: g.idx = 7'd66;
                8'h5C: g.idx = 7'd67;
                default: g.known = 1'b0;
            endcase
        end
        if (code == CHAR_SMALL_X && prev == CHAR_ZERO) begin
            g.known = 1'b1;
            g.idx   = IDX_SMALL_X;
        end
        return g;
    endfunction

    // Glyph bitmap, top row in the high bits, left column first within a row.
    function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [IDX_W-1:0] idx);
        logic [GLYPH_CELLS-1:0] b;
        case (idx)
            7'd0:  b = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            7'd1:  b = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            7'd2:  b = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            7'd3:  b = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
            7'd4:  b = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            7'd5:  b = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
            7'd6:  b = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            7'd7:  b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            7'd8:  b = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            7'd9:  b = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
            7'd10: b = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            7'd11: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            7'd12: b = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            7'd13: b = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            7'd14: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            7'd15: b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            7'd16: b = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            7'd17: b = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            7'd18: b = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            7'd19: b = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
            7'd20: b = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            7'd21: b = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            7'd22: b = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            7'd23: b = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
            7'd24: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            7'd25: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            7'd26: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            7'd27: b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            7'd28: b = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            7'd29: b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            7'd30: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            7'd31: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            7'd32: b = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            7'd33: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            7'd34: b = {5'h11, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04};
            7'd35: b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            7'd36: b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            7'd37: b = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            7'd38: b = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
            7'd39: b = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            7'd40: b = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
            7'd41: b = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
            7'd42: b = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            7'd43: b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            7'd44: b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
            7'd45: b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h04, 5'h08};
            7'd46: b = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
            7'd47: b = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            7'd48: b = {5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
            7'd49: b = {5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03};
            7'd50: b = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
            7'd51: b = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
            7'd52: b = {5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02};
            7'd53: b = {5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08};
            7'd54: b = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            7'd55: b = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            7'd56: b = {5'h0C, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00};
            7'd57: b = {5'h0A, 5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00};
            7'd58: b = {5'h00, 5'h04, 5'h15, 5'h0E, 5'h15, 5'h04, 5'h00};
            7'd59: b = {5'h0C, 5'h12, 5'h14, 5'h08, 5'h15, 5'h12, 5'h0D};
            7'd60: b = {5'h0E, 5'h11, 5'h01, 5'h0D, 5'h15, 5'h15, 5'h0E};
            7'd61: b = {5'h04, 5'h0F, 5'h14, 5'h0E, 5'h05, 5'h1E, 5'h04};
            7'd62: b = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h04, 5'h08};
            7'd63: b = {5'h02, 5'h04, 5'h04, 5'h08, 5'h04, 5'h04, 5'h02};
            7'd64: b = {5'h08, 5'h04, 5'h04, 5'h02, 5'h04, 5'h04, 5'h08};
            7'd65: b = {5'h00, 5'h00, 5'h08, 5'h15, 5'h02, 5'h00, 5'h00};
            7'd66: b = {5'h04, 5'h0A, 5'h11, 5'h00, 5'h00, 5'h00, 5'h00};
            7'd67: b = {5'h10, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h01};
            7'd68: b = {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/tgr_addu.sv
// Shared coordinate adder: base plus 1, 2, 4 or 6 times the cell scale.
// Depends on tgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgr_addu
    import tgr_pkg::*;
(
    input  wire logic [COORD_W-1:0] i_a,
    input  wire logic [SCALE_W-1:0] i_scale,
    input  wire t_mul               i_mul,
    output logic      [COORD_W-1:0] o_sum
);

    logic [MULT_W-1:0] w_b;

    always_comb begin
        unique case (i_mul)
            MUL1: w_b = MULT_W'(i_scale);
            MUL2: w_b = MULT_W'({i_scale, 1'b0});
            MUL4: w_b = MULT_W'({i_scale, 2'b00});
            MUL6: w_b = MULT_W'({i_scale, 2'b00}) + MULT_W'({i_scale, 1'b0});
            default: w_b = '0;
        endcase
    end

    assign o_sum = i_a + COORD_W'(w_b);

endmodule

`default_nettype wire

// File: sv/tgr_ctrl.sv
// Sequencer of the glyph generator: pen state, font lookup, cell scan and
// rectangle corner updates through one shared adder. Depends on tgr_pkg, tgr_addu.
`timescale 1ns / 1ps
`default_nettype none

module tgr_ctrl
    import tgr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_item            i_in,
    input  wire logic [POS_W-1:0] i_canvas,
    input  wire logic             i_out_free,
    output t_emit                 o_emit
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_K_X1,
        S_K_Y1,
        S_U_X1,
        S_U_Y1,
        S_U_Y0,
        S_U_X0,
        S_SCAN,
        S_UNK,
        S_BLANK
    } t_state;

    t_state                 r_state;
    logic [COORD_W-1:0]     r_pen_x;
    logic [POS_W-1:0]       r_pen_y;
    logic [CHAR_W-1:0]      r_prior;
    logic                   r_stopped;

    logic [CHAR_W-1:0]      r_code;
    logic [SCALE_W-1:0]     r_scale;
    logic [COLOR_W-1:0]     r_color;
    t_gsel                  r_gsel;
    logic [GLYPH_CELLS-1:0] r_bits;
    logic [COL_W-1:0]       r_col;
    logic [COORD_W-1:0]     r_xb;    // left edge of the glyph
    logic [COORD_W-1:0]     r_xs1;   // right edge of the first column
    logic [COORD_W-1:0]     r_cx;
    logic [COORD_W-1:0]     r_cx1;
    logic [COORD_W-1:0]     r_ry;
    logic [COORD_W-1:0]     r_ry1;

    logic [COORD_W-1:0]     w_a;
    t_mul                   w_mul;
    logic [COORD_W-1:0]     w_sum;
    t_gsel                  w_gsel;
    logic                   w_lit;
    logic                   w_tail_zero;
    logic                   w_wrap;
    logic                   w_step;

    assign w_gsel      = glyph_find(r_code, r_prior);
    assign w_lit       = r_bits[GLYPH_CELLS-1];
    assign w_tail_zero = (r_bits[GLYPH_CELLS-2:0] == '0);
    assign w_wrap      = (r_col == COL_W'(GLYPH_COLS - 1));
    assign w_step      = !w_lit || i_out_free;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        w_a   = r_cx;
        w_mul = MUL1;
        unique case (r_state)
            S_LOAD: begin
                w_a   = r_pen_x;
                w_mul = MUL6;
            end
            S_K_X1: w_a = r_cx;
            S_K_Y1: w_a = r_ry;
            S_U_X1: begin
                w_a   = r_cx;
                w_mul = MUL4;
            end
            S_U_Y1: begin
                w_a   = r_ry;
                w_mul = MUL6;
            end
            S_U_Y0: begin
                w_a   = r_ry;
                w_mul = MUL2;
            end
            S_U_X0: w_a = r_cx;
            S_SCAN: w_a = w_wrap ? r_ry1 : r_cx1;
            default: w_a = r_cx;
        endcase
    end

    tgr_addu u_addu (
        .i_a     (w_a),
        .i_scale (r_scale),
        .i_mul   (w_mul),
        .o_sum   (w_sum)
    );

    always_comb begin
        o_emit                   = '0;
        o_emit.beat.cursor_after = r_pen_x;
        o_emit.beat.last         = 1'b1;
        unique case (r_state)
            S_SCAN, S_UNK: begin
                o_emit.vld             = (r_state == S_UNK) ? i_out_free
                                                            : (w_lit && i_out_free);
                o_emit.beat.rect_x0    = r_cx;
                o_emit.beat.rect_y0    = r_ry;
                o_emit.beat.rect_x1    = r_cx1;
                o_emit.beat.rect_y1    = r_ry1;
                o_emit.beat.fill_color = r_color;
                o_emit.beat.has_rect   = 1'b1;
                o_emit.beat.last       = (r_state == S_UNK) || w_tail_zero;
            end
            S_BLANK: o_emit.vld = i_out_free;
            default: o_emit.vld = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_prior   <= CHAR_SPACE;
            r_stopped <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_code  <= i_in.char_code;
                        r_scale <= i_in.scale;
                        r_color <= i_in.color;
                        if (i_in.first) begin
                            r_pen_x   <= COORD_W'(i_in.start_x);
                            r_pen_y   <= i_in.start_y;
                            r_prior   <= CHAR_SPACE;
                            r_stopped <= 1'b0;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_stopped || r_pen_x > COORD_W'(i_canvas)) begin
                        r_stopped <= 1'b1;
                        r_state   <= S_BLANK;
                    end else begin
                        r_gsel  <= w_gsel;
                        r_prior <= r_code;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_bits  <= r_gsel.known ? glyph_bits(r_gsel.idx) : '0;
                    r_pen_x <= w_sum;
                    r_xb    <= r_pen_x;
                    r_cx    <= r_pen_x;
                    r_ry    <= COORD_W'(r_pen_y);
                    r_col   <= '0;
                    r_state <= r_gsel.known ? S_K_X1 : S_U_X1;
                end
                S_K_X1: begin
                    r_cx1   <= w_sum;
                    r_xs1   <= w_sum;
                    r_state <= S_K_Y1;
                end
                S_K_Y1: begin
                    r_ry1   <= w_sum;
                    r_state <= (r_bits == '0) ? S_BLANK : S_SCAN;
                end
                S_U_X1: begin
                    r_cx1   <= w_sum;
                    r_state <= S_U_Y1;
                end
                S_U_Y1: begin
                    r_ry1   <= w_sum;
                    r_state <= S_U_Y0;
                end
                S_U_Y0: begin
                    r_ry    <= w_sum;
                    r_state <= S_U_X0;
                end
                S_U_X0: begin
                    r_cx    <= w_sum;
                    r_state <= S_UNK;
                end
                S_SCAN: begin
                    if (w_step) begin
                        r_bits <= {r_bits[GLYPH_CELLS-2:0], 1'b0};
                        if (w_wrap) begin
                            r_col <= '0;
                            r_cx  <= r_xb;
                            r_cx1 <= r_xs1;
                            r_ry  <= r_ry1;
                            r_ry1 <= w_sum;
                        end else begin
                            r_col <= r_col + 1'b1;
                            r_cx  <= r_cx1;
                            r_cx1 <= w_sum;
                        end
                        if (w_tail_zero) r_state <= S_IDLE;
                    end
                end
                S_UNK, S_BLANK: begin
                    if (i_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the sequencer never starts a new item while it still has beats to give
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.vld && !o_emit.beat.last) |=> !o_in_ready)
        else $error("tgr_ctrl: ready while a character is unfinished");

    // a beat without a rectangle always closes its character
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.vld && !o_emit.beat.has_rect) |-> o_emit.beat.last)
        else $error("tgr_ctrl: blank beat not marked last");

    // the stop flag is only raised while checking the pen
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stopped) |-> $past(r_state) == S_CHECK)
        else $error("tgr_ctrl: stop flag set outside the pen check");

endmodule

`default_nettype wire

// File: sv/text_glyph_rect_generator_core.sv
// Top level of the text glyph rectangle generator: stream ports, canvas width
// register and output beat register. Depends on tgr_pkg and tgr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Text glyph rectangle generator.
// One input beat is one character; a beat with tuser (first) set opens a new
// string at start_x/start_y. Each lit cell of the 5x7 font glyph leaves as one
// filled scale-by-scale rectangle on the master stream, row by row, left column
// first; tlast marks the final beat of a character, tuser is has_rect.
// Unknown characters give one box; blank glyphs and characters past the canvas
// width give a single beat with has_rect low.
// Sequence: the block takes a character, then runs the pen check, font
// lookup and corner setup in the shared adder, then scans cells one per cycle,
// while the output register has room for a lit cell, up to the last lit cell.
// s_axis_tready is high only while the sequencer is idle, so a new character
// waits until the sequencer is through with the last one.
// A receiver stall holds the output beat register, and the scan waits on the
// next lit cell; the next character is taken while the final beat still waits.
// Reset (synchronous, active low) sets the pen to 0,0, the previous character
// to space, clears the stop flag and loads canvas_width with 1080.
// canvas_width is written through i_cfg_we/i_cfg_wdata; the user must write it only while idle (not enforced).

module text_glyph_rect_generator_core
    import tgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_wdata,    // canvas_width
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // char_code[7:0], start_x[19:8], start_y[31:20], scale[35:32],
    // color[59:36], zero[63:60]
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // first
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // rect_x0[12:0], rect_y0[25:13], rect_x1[38:26], rect_y1[51:39],
    // fill_color[75:52], cursor_after[88:76], zero[95:89]
    output logic [95:0]      m_axis_tdata,
    output logic             m_axis_tuser,   // has_rect
    output logic             m_axis_tlast    // last
);

    localparam logic [POS_W-1:0] CANVAS_RESET = 12'd1080;

    logic [POS_W-1:0] r_canvas;
    logic             r_ovalid;
    t_beat            r_obeat;

    t_item            w_item;
    t_emit            w_emit;
    logic             w_out_free;

    // unpack the slave beat
    assign w_item.char_code = s_axis_tdata[7:0];
    assign w_item.start_x   = s_axis_tdata[19:8];
    assign w_item.start_y   = s_axis_tdata[31:20];
    assign w_item.scale     = s_axis_tdata[35:32];
    assign w_item.color     = s_axis_tdata[59:36];
    assign w_item.first     = s_axis_tuser;

    // output register is free when empty or when its beat leaves this cycle
    assign w_out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas <= CANVAS_RESET;
        end else if (i_cfg_we) begin
            r_canvas <= i_cfg_wdata;
        end
    end

    tgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in       (w_item),
        .i_canvas   (r_canvas),
        .i_out_free (w_out_free),
        .o_emit     (w_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit.vld) begin
                r_ovalid <= 1'b1;
                r_obeat  <= w_emit.beat;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_obeat.cursor_after, r_obeat.fill_color,
                            r_obeat.rect_y1, r_obeat.rect_x1,
                            r_obeat.rect_y0, r_obeat.rect_x0};
    assign m_axis_tuser  = r_obeat.has_rect;
    assign m_axis_tlast  = r_obeat.last;

    // the sequencer only writes the output register when it has room
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.vld |-> (!r_ovalid || m_axis_tready))
        else $error("core: beat written over a pending beat");

    // a blank beat carries no rectangle and no color
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[75:0] == '0))
        else $error("core: blank beat with rectangle data");

    // a taken character keeps the slave side closed on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("core: second character taken back to back");

endmodule

`default_nettype wire
